// ----- rtl/tensor_transpose_index_map_unit_assert.svh -----
// assertion macros for the transpose index mapper
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef TENSOR_TRANSPOSE_INDEX_MAP_UNIT_ASSERT_SVH
`define TENSOR_TRANSPOSE_INDEX_MAP_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TTIM_ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication check failed");
`define TTIM_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");
`else
`define TTIM_ASSERT_IMPLY(lbl, clk, rst_n, a, c)
`define TTIM_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

// ----- rtl/ttim_pkg.sv -----
// shared types, constants and helper functions of the transpose index mapper
// no dependencies
package ttim_pkg;

  localparam int IW           = 32;
  localparam int SW           = 16;
  localparam int AXES         = 6;
  localparam int MAX_RANK     = 6;
  localparam int AXIS_SLOTS   = 8;
  localparam int RANK_W       = 3;
  localparam int ORDER_W      = 18;
  localparam int DIMS_W       = 48;
  localparam int CFG_IDX_W    = 3;
  localparam int STATUS_W     = 2;
  localparam int DIV_BITS     = 2;
  localparam int DIV_STAGES   = IW / DIV_BITS;
  localparam int UNIT_STAGES  = DIV_STAGES + 2;
  localparam int FRONT_STAGES = 8;
  localparam int LATENCY      = FRONT_STAGES + 1 + AXES * UNIT_STAGES + 1;

  localparam logic [CFG_IDX_W-1:0] REG_RANK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REV   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INNER = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ORDER = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;

  typedef struct packed {
    logic                      err;
    logic [IW:0]               count;
    logic [AXES-1:0][SW-1:0]   size;
    logic [AXES-1:0][IW-1:0]   stride;
  } ttim_derived_t;

  typedef struct packed {
    logic                valid;
    logic [IW-1:0]       num;
    logic [SW-1:0]       rem;
    logic [IW-1:0]       acc;
    logic [STATUS_W-1:0] status;
  } ttim_item_t;

  typedef struct packed {
    logic [SW-1:0] rem;
    logic [IW-1:0] num;
  } ttim_div_t;

  // restoring division, DIV_BITS quotient bits shifted into num
  function automatic ttim_div_t ttim_div_step(ttim_div_t cur, logic [SW-1:0] d);
    ttim_div_t   r;
    logic [SW:0] t;
    r = cur;
    for (int b = 0; b < DIV_BITS; b++) begin
      t = {r.rem, r.num[IW-1]};
      if (t >= {1'b0, d}) begin
        r.rem = SW'(t - {1'b0, d});
        r.num = {r.num[IW-2:0], 1'b1};
      end else begin
        r.rem = t[SW-1:0];
        r.num = {r.num[IW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // element count saturating at 2^IW, which is beyond any index
  function automatic logic [IW:0] ttim_sat_mul(logic [IW:0] a, logic [SW-1:0] b);
    logic [IW+SW:0] p;
    p = {{SW{1'b0}}, a} * {{(IW+1){1'b0}}, b};
    if (p > {{SW{1'b0}}, 1'b1, {IW{1'b0}}}) begin
      return {1'b1, {IW{1'b0}}};
    end
    return p[IW:0];
  endfunction

endpackage

// ----- rtl/ttim_cfg_regs.sv -----
// configuration registers and derived shape data (sizes, strides, count)
// depends on ttim_pkg
module ttim_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [ttim_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [ttim_pkg::DIMS_W-1:0]       wr_data,
  output ttim_pkg::ttim_derived_t           derived
);

  logic [ttim_pkg::RANK_W-1:0]  rank_r;
  logic                         rev_r;
  logic [ttim_pkg::ORDER_W-1:0] order_r;
  logic [ttim_pkg::DIMS_W-1:0]  outer_r;
  logic [ttim_pkg::DIMS_W-1:0]  inner_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r  <= '0;
      rev_r   <= 1'b1;
      order_r <= '0;
      outer_r <= '0;
      inner_r <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        ttim_pkg::REG_RANK:  rank_r  <= wr_data[ttim_pkg::RANK_W-1:0];
        ttim_pkg::REG_REV:   rev_r   <= wr_data[0];
        ttim_pkg::REG_ORDER: order_r <= wr_data[ttim_pkg::ORDER_W-1:0];
        ttim_pkg::REG_OUTER: outer_r <= wr_data;
        ttim_pkg::REG_INNER: inner_r <= wr_data;
        default: ;
      endcase
    end
  end

  logic [ttim_pkg::AXIS_SLOTS-1:0][ttim_pkg::SW-1:0] size;
  logic [ttim_pkg::AXES-1:0][ttim_pkg::SW-1:0]       sizep;
  logic [ttim_pkg::AXES-1:0][ttim_pkg::RANK_W-1:0]   perm;
  logic                                              bad;

  always_comb begin
    size = '0;
    for (int i = 0; i < 3; i++) begin
      size[i]     = outer_r[16*i +: 16];
      size[i + 3] = inner_r[16*i +: 16];
    end
    for (int i = 0; i < ttim_pkg::AXES; i++) begin
      sizep[i] = (3'(i) < rank_r) ? size[i] : 16'd1;
    end
  end

  always_comb begin
    bad = (rank_r > 3'(ttim_pkg::MAX_RANK)) || (rank_r > 3'(ttim_pkg::AXES));
    for (int j = 0; j < ttim_pkg::AXES; j++) begin
      perm[j] = rev_r ? 3'(rank_r - 3'(j) - 3'd1) : order_r[3*j +: 3];
    end
    if (!rev_r) begin
      for (int j = 0; j < ttim_pkg::AXES; j++) begin
        if (3'(j) < rank_r) begin
          if (perm[j] >= rank_r) bad = 1'b1;
          for (int m = 0; m < j; m++) begin
            if (perm[m] == perm[j]) bad = 1'b1;
          end
        end
      end
    end
  end

  // suffix products give row-major strides, registered from the innermost axis outward
  logic [ttim_pkg::AXES-1:0][ttim_pkg::IW-1:0]       sfx_r;
  logic [ttim_pkg::AXIS_SLOTS-1:0][ttim_pkg::IW-1:0] sfx_sel;
  logic [ttim_pkg::AXES-1:0][ttim_pkg::IW:0]         cnt_r;
  logic [ttim_pkg::AXES-1:0][ttim_pkg::RANK_W-1:0]   perm_r;
  logic                                              err_r;
  logic [ttim_pkg::AXES-1:0][ttim_pkg::SW-1:0]       size_out_r;
  logic [ttim_pkg::AXES-1:0][ttim_pkg::IW-1:0]       stride_out_r;

  always_ff @(posedge clk) begin
    sfx_r[ttim_pkg::AXES-1] <= ttim_pkg::IW'(1);
    for (int i = 0; i < ttim_pkg::AXES - 1; i++) begin
      sfx_r[i] <= ttim_pkg::IW'(sfx_r[i+1] *
                  {{(ttim_pkg::IW-ttim_pkg::SW){1'b0}}, sizep[i+1]});
    end
    cnt_r[ttim_pkg::AXES-1] <= ttim_pkg::ttim_sat_mul((ttim_pkg::IW+1)'(1),
                                                      sizep[ttim_pkg::AXES-1]);
    for (int i = 0; i < ttim_pkg::AXES - 1; i++) begin
      cnt_r[i] <= ttim_pkg::ttim_sat_mul(cnt_r[i+1], sizep[i]);
    end
    perm_r <= perm;
    err_r  <= bad;
  end

  always_comb begin
    sfx_sel = '0;
    for (int i = 0; i < ttim_pkg::AXES; i++) sfx_sel[i] = sfx_r[i];
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < ttim_pkg::AXES; j++) begin
      if (3'(j) < rank_r) begin
        size_out_r[j]   <= size[perm_r[j]];
        stride_out_r[j] <= sfx_sel[perm_r[j]];
      end else begin
        size_out_r[j]   <= 16'd1;
        stride_out_r[j] <= '0;
      end
    end
  end

  assign derived.err    = err_r;
  assign derived.count  = cnt_r[0];
  assign derived.size   = size_out_r;
  assign derived.stride = stride_out_r;

endmodule

// ----- rtl/ttim_axis_unit.sv -----
// one output axis: pipelined divide by the axis size, then coordinate times stride
// depends on ttim_pkg
module ttim_axis_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ttim_pkg::ttim_item_t         in_item,
  input  logic [ttim_pkg::SW-1:0]      divisor,
  input  logic [ttim_pkg::IW-1:0]      stride,
  output ttim_pkg::ttim_item_t         out_item
);

  ttim_pkg::ttim_item_t div_r   [ttim_pkg::DIV_STAGES];
  ttim_pkg::ttim_item_t div_nxt [ttim_pkg::DIV_STAGES];

  for (genvar s = 0; s < ttim_pkg::DIV_STAGES; s++) begin : g_div
    ttim_pkg::ttim_item_t src;
    ttim_pkg::ttim_div_t  cur;
    ttim_pkg::ttim_div_t  res;
    if (s == 0) begin : g_first
      always_comb begin
        src     = in_item;
        src.rem = '0;
      end
    end else begin : g_rest
      assign src = div_r[s-1];
    end
    always_comb begin
      cur.rem = src.rem;
      cur.num = src.num;
      res     = ttim_pkg::ttim_div_step(cur, divisor);
      div_nxt[s]     = src;
      div_nxt[s].rem = res.rem;
      div_nxt[s].num = res.num;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_r[s].valid <= 1'b0;
      end else begin
        div_r[s] <= div_nxt[s];
      end
    end
  end

  // num now holds the quotient, rem the coordinate on this axis
  ttim_pkg::ttim_item_t     mul_r;
  logic [ttim_pkg::IW-1:0]  prod_r;
  ttim_pkg::ttim_item_t     add_r;
  ttim_pkg::ttim_item_t     add_nxt;

  always_comb begin
    add_nxt     = mul_r;
    add_nxt.acc = mul_r.acc + prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r.valid <= 1'b0;
      add_r.valid <= 1'b0;
    end else begin
      mul_r  <= div_r[ttim_pkg::DIV_STAGES-1];
      prod_r <= ttim_pkg::IW'(
                  {{(ttim_pkg::IW-ttim_pkg::SW){1'b0}}, div_r[ttim_pkg::DIV_STAGES-1].rem}
                  * stride);
      add_r  <= add_nxt;
    end
  end

  assign out_item = add_r;

endmodule

// ----- rtl/tensor_transpose_index_map_unit.sv -----
// top level of the transpose index mapper: config port, front delay, axis units
// depends on ttim_pkg, ttim_cfg_regs, ttim_axis_unit and the assertion header
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+-------------------
//  input   | in_dest_index                                 | start & !busy
//  result  | out_source_index, out_status                  | out_valid strobe
//  config  | cfg_index, cfg_data                           | cfg_valid & cfg_ready
//
// one word in per cycle, one result per word; a word passes the front delay, the
// check register, six axis units of 16 two-bit divide stages each and the output register.
// busy is high only during reset and the cycle after it.
// synchronous active-low reset clears all valid bits; no stalls occur.
`include "tensor_transpose_index_map_unit_assert.svh"
module tensor_transpose_index_map_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [ttim_pkg::IW-1:0]           in_dest_index,
  output logic                              out_valid,
  output logic [ttim_pkg::IW-1:0]           out_source_index,
  output logic [ttim_pkg::STATUS_W-1:0]     out_status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ttim_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ttim_pkg::DIMS_W-1:0]       cfg_data
);

  logic busy_r;
  logic cfg_ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      cfg_ready_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      cfg_ready_r <= 1'b1;
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = cfg_ready_r;

  ttim_pkg::ttim_derived_t derived;

  ttim_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready_r),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .derived  (derived)
  );

  // front delay lets derived shape data settle after a config write
  logic                    front_vld_r [ttim_pkg::FRONT_STAGES];
  logic [ttim_pkg::IW-1:0] front_idx_r [ttim_pkg::FRONT_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ttim_pkg::FRONT_STAGES; s++) front_vld_r[s] <= 1'b0;
    end else begin
      front_vld_r[0] <= start && !busy_r;
      for (int s = 1; s < ttim_pkg::FRONT_STAGES; s++) begin
        front_vld_r[s] <= front_vld_r[s-1];
      end
    end
    front_idx_r[0] <= in_dest_index;
    for (int s = 1; s < ttim_pkg::FRONT_STAGES; s++) begin
      front_idx_r[s] <= front_idx_r[s-1];
    end
  end

  ttim_pkg::ttim_item_t chk_r;
  logic [ttim_pkg::IW-1:0] last_idx;

  assign last_idx = front_idx_r[ttim_pkg::FRONT_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r.valid <= 1'b0;
    end else begin
      chk_r.valid <= front_vld_r[ttim_pkg::FRONT_STAGES-1];
      chk_r.num   <= last_idx;
      chk_r.rem   <= '0;
      chk_r.acc   <= '0;
      if (derived.err) begin
        chk_r.status <= ttim_pkg::STATUS_BAD_ORDER;
      end else if ({1'b0, last_idx} >= derived.count) begin
        chk_r.status <= ttim_pkg::STATUS_RANGE;
      end else begin
        chk_r.status <= ttim_pkg::STATUS_OK;
      end
    end
  end

  // innermost output axis first
  ttim_pkg::ttim_item_t chain [ttim_pkg::AXES+1];
  assign chain[0] = chk_r;

  for (genvar k = 0; k < ttim_pkg::AXES; k++) begin : g_axis
    ttim_axis_unit u_axis (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_item  (chain[k]),
      .divisor  (derived.size[ttim_pkg::AXES-1-k]),
      .stride   (derived.stride[ttim_pkg::AXES-1-k]),
      .out_item (chain[k+1])
    );
  end

  logic                          out_valid_r;
  logic [ttim_pkg::IW-1:0]       out_src_r;
  logic [ttim_pkg::STATUS_W-1:0] out_status_r;
  ttim_pkg::ttim_item_t          fin;

  assign fin = chain[ttim_pkg::AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= fin.valid;
      out_status_r <= fin.status;
      out_src_r    <= (fin.status == ttim_pkg::STATUS_OK) ? fin.acc : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_source_index = out_src_r;
  assign out_status       = out_status_r;

  `TTIM_ASSERT_IMPLY(a_err_zero, clk, rst_n,
    out_valid && (out_status != ttim_pkg::STATUS_OK), out_source_index == '0)
  `TTIM_ASSERT_IMPLY(a_latency, clk, rst_n, 1'b1,
    out_valid == $past(start && !busy, ttim_pkg::LATENCY))
  `TTIM_ASSERT_NEXT(a_busy_low, clk, rst_n, !busy, !busy && cfg_ready)

endmodule
